/* hdl/lpmt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the longest-prefix-match table.
// Used by lpmt_cmp, longest_prefix_match_table_unit and the testbench; depends on nothing.

package lpmt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PEER_ID_BITS  = 8;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(TABLE_ENTRIES);

    localparam logic [7:0] V4_KEY_LEN = 8'd32;
    localparam logic [7:0] V6_KEY_LEN = 8'd128;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                    family;
        logic [63:0]             prefix_hi;
        logic [63:0]             prefix_lo;
        logic [7:0]              len;
        logic [PEER_ID_BITS-1:0] peer;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic lpm_hit;
        logic exact_hit;
        logic peer_hit;
    } t_cmp_res;

    function automatic logic [127:0] prefix_mask(input logic v6, input logic [7:0] len);
        logic [127:0] ones6;
        logic [31:0]  ones4;
        ones6 = '1;
        ones4 = '1;
        if (v6) begin
            return ~(ones6 >> len);
        end
        return {96'd0, ~(ones4 >> len)};
    endfunction

    function automatic logic [PEER_ID_BITS-1:0] peer_from_port(input logic [7:0] p);
        logic [PEER_ID_BITS+7:0] ext;
        ext = {{PEER_ID_BITS{1'b0}}, p};
        return ext[PEER_ID_BITS-1:0];
    endfunction

    function automatic logic [7:0] peer_to_port(input logic [PEER_ID_BITS-1:0] p);
        logic [PEER_ID_BITS+7:0] ext;
        ext = {8'd0, p};
        return ext[7:0];
    endfunction

endpackage

/* hdl/lpmt_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the entry words of the prefix table.

module lpmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lpmt_cmp.sv */
`timescale 1ns / 1ps
// Shared entry comparator: matches one stored entry against the request key.
// Depends on lpmt_pkg.

module lpmt_cmp (
    input  lpmt_pkg::t_entry   i_key,
    input  lpmt_pkg::t_entry   i_entry,
    input  logic               i_valid,
    output lpmt_pkg::t_cmp_res o_res
);

    logic [127:0] w_mask;
    logic [127:0] w_masked;
    logic         w_prefix_eq;

    assign w_mask      = lpmt_pkg::prefix_mask(i_key.family, i_entry.len);
    assign w_masked    = {i_key.prefix_hi, i_key.prefix_lo} & w_mask;
    assign w_prefix_eq = (w_masked == {i_entry.prefix_hi, i_entry.prefix_lo})
                         && (i_entry.family == i_key.family);

    // An insert key is already masked to its own length, so an exact match is
    // a covering match of equal length.
    assign o_res.lpm_hit   = i_valid && w_prefix_eq;
    assign o_res.exact_hit = i_valid && w_prefix_eq && (i_entry.len == i_key.len);
    assign o_res.peer_hit  = i_valid && (i_entry.peer == i_key.peer);

endmodule

/* hdl/longest_prefix_match_table_unit.sv */
`timescale 1ns / 1ps
// Top level of the longest-prefix-match table: sequencer, valid bits and counter.
// Depends on lpmt_pkg, lpmt_ram and lpmt_cmp.
//
//   channel   direction  tdata                                   tuser
//   s_axis    in         addr_hi, addr_lo, prefix_len, peer_in   req_type, is_v6
//   m_axis    out        peer_out, entry_count                   status, hit
//
// Every accepted valid word scans the whole table through one comparator, one entry
// per cycle from the registered RAM read.
// An invalid insert or an unused request skips the scan and goes straight to finish.
// Reset empties the table at once through the valid bits.
// A new word is taken once the previous result sits in the output register;
// a stalled output holds the sequencer before it loads the next result.

module longest_prefix_match_table_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // addr_hi, addr_lo, prefix_len, peer_in
    input  logic [2:0]   s_axis_tuser,  // req_type, is_v6
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,  // peer_out, entry_count, zero pad
    output logic [2:0]   m_axis_tuser   // status, hit
);

    localparam int N = lpmt_pkg::TABLE_ENTRIES;
    localparam int IW = lpmt_pkg::IDX_W;
    localparam int CW = lpmt_pkg::CNT_W;
    localparam int PW = lpmt_pkg::PEER_ID_BITS;

    lpmt_pkg::t_state   r_state, n_state;
    logic [N-1:0]       r_valid, n_valid;
    logic [CW-1:0]      r_count, n_count;
    logic [IW:0]        r_rd_cnt, n_rd_cnt;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]      r_cmp_idx, n_cmp_idx;
    lpmt_pkg::t_entry   r_key, n_key;
    lpmt_pkg::t_req     r_req, n_req;
    logic               r_bad, n_bad;
    logic               r_hit, n_hit;
    logic [7:0]         r_best_len, n_best_len;
    logic [PW-1:0]      r_best_peer, n_best_peer;
    logic               r_slot_found, n_slot_found;
    logic [IW-1:0]      r_slot, n_slot;
    logic               r_free_found, n_free_found;
    logic [IW-1:0]      r_free, n_free;
    logic               r_o_valid, n_o_valid;
    lpmt_pkg::t_status  r_o_status, n_o_status;
    logic               r_o_hit, n_o_hit;
    logic [7:0]         r_o_peer, n_o_peer;
    logic [6:0]         r_o_count, n_o_count;

    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    logic [lpmt_pkg::ENTRY_W-1:0] w_rdata;
    lpmt_pkg::t_entry       w_entry;
    lpmt_pkg::t_cmp_res     w_cmp;
    logic                   w_out_free;
    logic [CW+6:0]          w_cnt_ext;

    logic                   w_in_v6;
    lpmt_pkg::t_req         w_in_req;
    logic [63:0]            w_in_hi;
    logic [63:0]            w_in_lo;
    logic [7:0]             w_in_len;
    logic [PW-1:0]          w_in_peer;
    logic [127:0]           w_in_mask;
    logic [7:0]             w_in_max;

    lpmt_ram #(
        .WIDTH (lpmt_pkg::ENTRY_W),
        .DEPTH (N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_raddr (r_rd_cnt[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_entry = lpmt_pkg::t_entry'(w_rdata);

    lpmt_cmp u_cmp (
        .i_key   (r_key),
        .i_entry (w_entry),
        .i_valid (r_valid[r_cmp_idx]),
        .o_res   (w_cmp)
    );

    assign w_in_req  = lpmt_pkg::t_req'(s_axis_tuser[1:0]);
    assign w_in_v6   = s_axis_tuser[2];
    assign w_in_hi   = w_in_v6 ? s_axis_tdata[63:0] : 64'd0;
    assign w_in_lo   = w_in_v6 ? s_axis_tdata[127:64] : {32'd0, s_axis_tdata[95:64]};
    assign w_in_len  = s_axis_tdata[135:128];
    assign w_in_peer = lpmt_pkg::peer_from_port(s_axis_tdata[143:136]);
    assign w_in_mask = lpmt_pkg::prefix_mask(w_in_v6, w_in_len);
    assign w_in_max  = w_in_v6 ? lpmt_pkg::V6_KEY_LEN : lpmt_pkg::V4_KEY_LEN;

    assign w_out_free = !r_o_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_count      = r_count;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_key        = r_key;
        n_req        = r_req;
        n_bad        = r_bad;
        n_hit        = r_hit;
        n_best_len   = r_best_len;
        n_best_peer  = r_best_peer;
        n_slot_found = r_slot_found;
        n_slot       = r_slot;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_o_valid    = r_o_valid && !m_axis_tready;
        n_o_status   = r_o_status;
        n_o_hit      = r_o_hit;
        n_o_peer     = r_o_peer;
        n_o_count    = r_o_count;
        w_we         = 1'b0;
        w_waddr      = r_slot;
        w_cnt_ext    = {7'd0, r_count};

        unique case (r_state)
            lpmt_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req            = w_in_req;
                    n_key.family     = w_in_v6;
                    n_key.len        = w_in_len;
                    n_key.peer       = w_in_peer;
                    n_key.prefix_hi  = w_in_hi;
                    n_key.prefix_lo  = w_in_lo;
                    if (w_in_req == lpmt_pkg::REQ_INSERT) begin
                        n_key.prefix_hi = w_in_hi & w_in_mask[127:64];
                        n_key.prefix_lo = w_in_lo & w_in_mask[63:0];
                    end
                    n_bad = (w_in_req == lpmt_pkg::REQ_UNUSED)
                            || ((w_in_req == lpmt_pkg::REQ_INSERT)
                                && ((w_in_len > w_in_max) || (w_in_peer == '0)));
                    n_rd_cnt     = '0;
                    n_hit        = 1'b0;
                    n_slot_found = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = n_bad ? lpmt_pkg::S_FINISH : lpmt_pkg::S_SCAN;
                end
            end
            lpmt_pkg::S_SCAN: begin
                if (r_rd_cnt != lpmt_pkg::SCAN_END) begin
                    n_rd_cnt  = r_rd_cnt + (IW + 1)'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_cnt[IW-1:0];
                end else if (!r_cmp_vld) begin
                    n_state = lpmt_pkg::S_FINISH;
                end
                if (r_cmp_vld) begin
                    unique case (r_req)
                        lpmt_pkg::REQ_LOOKUP: begin
                            if (w_cmp.lpm_hit && (!r_hit || (w_entry.len > r_best_len))) begin
                                n_hit       = 1'b1;
                                n_best_len  = w_entry.len;
                                n_best_peer = w_entry.peer;
                            end
                        end
                        lpmt_pkg::REQ_INSERT: begin
                            if (w_cmp.exact_hit && !r_slot_found) begin
                                n_slot_found = 1'b1;
                                n_slot       = r_cmp_idx;
                            end
                            if (!r_valid[r_cmp_idx] && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free       = r_cmp_idx;
                            end
                        end
                        lpmt_pkg::REQ_REMOVE: begin
                            if (w_cmp.peer_hit && (r_key.peer != '0)) begin
                                n_valid[r_cmp_idx] = 1'b0;
                                n_count            = r_count - CW'(1);
                            end
                        end
                        lpmt_pkg::REQ_UNUSED: begin
                        end
                    endcase
                end
            end
            lpmt_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = lpmt_pkg::ST_OK;
                    n_o_hit    = 1'b0;
                    n_o_peer   = 8'd0;
                    priority if (r_bad) begin
                        n_o_status = lpmt_pkg::ST_INVALID;
                    end else if (r_req == lpmt_pkg::REQ_LOOKUP) begin
                        n_o_hit  = r_hit;
                        n_o_peer = r_hit ? lpmt_pkg::peer_to_port(r_best_peer) : 8'd0;
                    end else if (r_req == lpmt_pkg::REQ_INSERT) begin
                        priority if (r_slot_found) begin
                            w_we    = 1'b1;
                            w_waddr = r_slot;
                        end else if (r_free_found) begin
                            w_we             = 1'b1;
                            w_waddr          = r_free;
                            n_valid[r_free]  = 1'b1;
                            n_count          = r_count + CW'(1);
                        end else begin
                            n_o_status = lpmt_pkg::ST_FULL;
                        end
                    end else begin
                    end
                    w_cnt_ext = {7'd0, n_count};
                    n_o_count = w_cnt_ext[6:0];
                    n_state   = lpmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lpmt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lpmt_pkg::S_IDLE;
            r_valid      <= '0;
            r_count      <= '0;
            r_rd_cnt     <= '0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_slot_found <= 1'b0;
            r_free_found <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_rd_cnt     <= n_rd_cnt;
            r_cmp_vld    <= n_cmp_vld;
            r_hit        <= n_hit;
            r_slot_found <= n_slot_found;
            r_free_found <= n_free_found;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= n_cmp_idx;
        r_key       <= n_key;
        r_req       <= n_req;
        r_bad       <= n_bad;
        r_best_len  <= n_best_len;
        r_best_peer <= n_best_peer;
        r_slot      <= n_slot;
        r_free      <= n_free;
        r_o_status  <= n_o_status;
        r_o_hit     <= n_o_hit;
        r_o_peer    <= n_o_peer;
        r_o_count   <= n_o_count;
    end

    assign s_axis_tready = (r_state == lpmt_pkg::S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o_count, r_o_peer};
    assign m_axis_tuser  = {r_o_hit, r_o_status};

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of longest_prefix_match_table_unit: directed edge cases,
// a table-full pass and random traffic, checked word by word against its own table model.
// Depends on lpmt_pkg and the RTL under hdl.

module testbench;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 70;
    localparam int RANDOM_WORDS = 2000;
    localparam int MAX_PRINTED  = 40;
    localparam int ENTRIES      = lpmt_pkg::TABLE_ENTRIES;
    localparam int PEER_BITS    = lpmt_pkg::PEER_ID_BITS;
    localparam bit [63:0] ONES64 = '1;

    typedef struct {
        bit                 valid;
        bit                 fam;
        bit [127:0]         pfx;
        bit [7:0]           len;
        bit [PEER_BITS-1:0] peer;
    } t_route;

    typedef struct {
        lpmt_pkg::t_status status;
        bit                hit;
        bit [7:0]          peer_out;
        bit [6:0]          count;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;   // addr_hi, addr_lo, prefix_len, peer_in
    logic [2:0]   s_axis_tuser;   // req_type, is_v6
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;   // peer_out, entry_count, zero pad
    logic [2:0]   m_axis_tuser;   // status, hit

    t_route  routes[ENTRIES];
    t_answer answers_due[$];
    int      err_count = 0;
    int      quiet_cycles = 0;
    bit      burst_mode;

    longest_prefix_match_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit [127:0] keep_mask(bit v6, bit [7:0] len);
        int         width;
        int         n;
        bit [127:0] ones;
        width = v6 ? 128 : 32;
        n     = (len > width) ? width : len;
        ones  = v6 ? {128{1'b1}} : 128'hFFFF_FFFF;
        if (n == 0) return '0;
        return (ones << (width - n)) & ones;
    endfunction

    function automatic bit [127:0] low_bits(int k);
        if (k == 0) return '0;
        return {128{1'b1}} >> (128 - k);
    endfunction

    function automatic bit [127:0] rand_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic int live_routes();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) if (routes[i].valid) n++;
        return n;
    endfunction

    function automatic t_answer table_step(lpmt_pkg::t_req req, bit v6, bit [63:0] hi,
                                           bit [63:0] lo, bit [7:0] len, bit [7:0] peer_in);
        t_answer            a;
        bit [127:0]         key;
        bit [127:0]         pfx;
        bit [PEER_BITS-1:0] pid;
        bit [7:0]           best_len;
        int                 slot;
        int                 free_slot;
        a        = '{status: lpmt_pkg::ST_OK, hit: 1'b0, peer_out: 8'd0, count: 7'd0};
        key      = v6 ? {hi, lo} : {96'd0, lo[31:0]};
        pid      = PEER_BITS'(peer_in);
        best_len = 8'd0;
        case (req)
            lpmt_pkg::REQ_LOOKUP: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (routes[i].valid && routes[i].fam == v6 &&
                        (key & keep_mask(v6, routes[i].len)) == routes[i].pfx &&
                        (!a.hit || routes[i].len > best_len)) begin
                        a.hit      = 1'b1;
                        best_len   = routes[i].len;
                        a.peer_out = 8'(routes[i].peer);
                    end
                end
            end
            lpmt_pkg::REQ_INSERT: begin
                if (len > (v6 ? 128 : 32) || pid == 0) begin
                    a.status = lpmt_pkg::ST_INVALID;
                end else begin
                    pfx       = key & keep_mask(v6, len);
                    slot      = -1;
                    free_slot = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!routes[i].valid) begin
                            if (free_slot < 0) free_slot = i;
                        end else if (slot < 0 && routes[i].fam == v6 &&
                                     routes[i].len == len && routes[i].pfx == pfx) begin
                            slot = i;
                        end
                    end
                    if (slot >= 0) begin
                        routes[slot].peer = pid;
                    end else if (free_slot >= 0) begin
                        routes[free_slot] = '{valid: 1'b1, fam: v6, pfx: pfx, len: len,
                                              peer: pid};
                    end else begin
                        a.status = lpmt_pkg::ST_FULL;
                    end
                end
            end
            lpmt_pkg::REQ_REMOVE: begin
                if (pid != 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (routes[i].valid && routes[i].peer == pid) routes[i].valid = 1'b0;
                    end
                end
            end
            default: begin
                a.status = lpmt_pkg::ST_INVALID;
            end
        endcase
        a.count = 7'(live_routes());
        return a;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < MAX_PRINTED) $display("testbench: mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic send_request(lpmt_pkg::t_req req, bit v6, bit [63:0] hi, bit [63:0] lo,
                                bit [7:0] len, bit [7:0] peer);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {peer, len, lo, hi};
        s_axis_tuser  = {v6, req};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        answers_due.push_back(table_step(req, v6, hi, lo, len, peer));
    endtask

    task automatic check_edges();
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b0, 64'd0, 64'd0, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b1, ONES64, ONES64, 8'd255, 8'd255);
        send_request(lpmt_pkg::REQ_UNUSED, 1'b1, ONES64, ONES64, 8'd8, 8'd7);
        send_request(lpmt_pkg::REQ_INSERT, 1'b0, 64'd0, 64'h0a00_0000, 8'd8, 8'd0);
        send_request(lpmt_pkg::REQ_INSERT, 1'b0, 64'd0, 64'h0a00_0000, 8'd33, 8'd1);
        send_request(lpmt_pkg::REQ_INSERT, 1'b1, 64'd0, 64'd0, 8'd129, 8'd1);
        send_request(lpmt_pkg::REQ_INSERT, 1'b1, 64'd0, 64'd0, 8'd255, 8'd255);
        send_request(lpmt_pkg::REQ_REMOVE, 1'b0, 64'd0, 64'd0, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_INSERT, 1'b0, ONES64, 64'hffff_ffff_c0a8_0101, 8'd0, 8'd1);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b0, 64'd0, 64'h1234_5678, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b1, 64'd0, 64'h1234_5678, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_INSERT, 1'b0, 64'd0, 64'hffff_ffff, 8'd32, 8'd255);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b0, ONES64, ONES64, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_INSERT, 1'b0, 64'd0, 64'hc0a8_01ff, 8'd24, 8'd6);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b0, 64'd0, 64'hc0a8_0107, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_INSERT, 1'b1, ONES64, ONES64, 8'd128, 8'd2);
        send_request(lpmt_pkg::REQ_INSERT, 1'b1, 64'h2001_0db8_0000_0000, 64'd1, 8'd64, 8'd4);
        send_request(lpmt_pkg::REQ_INSERT, 1'b1, 64'd0, 64'd0, 8'd0, 8'd3);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b1, ONES64, ONES64, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b1, 64'h2001_0db8_0000_0000, 64'hdead_beef,
                     8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_INSERT, 1'b0, 64'd0, 64'h9999_9999, 8'd0, 8'd5);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b0, 64'd0, 64'h0101_0101, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_REMOVE, 1'b1, 64'd0, 64'd0, 8'd0, 8'd255);
        send_request(lpmt_pkg::REQ_LOOKUP, 1'b0, ONES64, ONES64, 8'd0, 8'd0);
        send_request(lpmt_pkg::REQ_REMOVE, 1'b0, 64'd0, 64'd0, 8'd0, 8'd5);
    endtask

    task automatic check_table_full();
        bit [127:0] key;
        int         pick;
        while (live_routes() < ENTRIES) begin
            key = rand_key();
            send_request(lpmt_pkg::REQ_INSERT, 1'b1, key[127:64], key[63:0], 8'd128,
                         8'($urandom_range(1, 255)));
        end
        key = rand_key();
        send_request(lpmt_pkg::REQ_INSERT, 1'b1, key[127:64], key[63:0], 8'd17, 8'd9);
        send_request(lpmt_pkg::REQ_INSERT, 1'b0, 64'd0, key[63:0], 8'd32, 8'd9);
        pick = $urandom_range(0, ENTRIES - 1);
        key  = routes[pick].pfx;
        send_request(lpmt_pkg::REQ_INSERT, routes[pick].fam, key[127:64], key[63:0],
                     routes[pick].len, 8'd200);
        send_request(lpmt_pkg::REQ_LOOKUP, routes[pick].fam, key[127:64], key[63:0],
                     8'd0, 8'd0);
        while (live_routes() != 0) begin
            pick = 0;
            while (!routes[pick].valid) pick++;
            send_request(lpmt_pkg::REQ_REMOVE, 1'($urandom_range(0, 1)), 64'd0, 64'd0, 8'd0,
                         8'(routes[pick].peer));
        end
    endtask

    task automatic check_random_traffic();
        bit [127:0]     base_keys[2][8];
        bit [127:0]     key;
        bit [63:0]      hi;
        bit [63:0]      lo;
        bit [7:0]       len;
        bit [7:0]       peer;
        bit             v6;
        lpmt_pkg::t_req req;
        int             width;
        int             p;
        for (int f = 0; f < 2; f++) begin
            for (int j = 0; j < 8; j++) base_keys[f][j] = rand_key();
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
            p     = $urandom_range(0, 99);
            req   = (p < 40) ? lpmt_pkg::REQ_LOOKUP : (p < 80) ? lpmt_pkg::REQ_INSERT :
                    (p < 94) ? lpmt_pkg::REQ_REMOVE : lpmt_pkg::REQ_UNUSED;
            v6    = 1'($urandom_range(0, 1));
            width = v6 ? 128 : 32;
            key   = ($urandom_range(0, 4) == 0) ? rand_key() :
                    base_keys[v6][$urandom_range(0, 7)] ^
                    (rand_key() & low_bits($urandom_range(0, width)));
            if (v6) begin
                {hi, lo} = key;
            end else begin
                hi = {$urandom, $urandom};
                lo = {$urandom, key[31:0]};
            end
            p = $urandom_range(0, 9);
            if (req != lpmt_pkg::REQ_INSERT || p == 9) begin
                len = 8'($urandom_range(0, 255));
            end else if (p < 6) begin
                len = 8'($urandom_range(0, width));
            end else begin
                case ($urandom_range(0, 3))
                    0:       len = 8'd0;
                    1:       len = 8'(width / 4);
                    2:       len = 8'(width / 2);
                    default: len = 8'(width);
                endcase
            end
            p    = $urandom_range(0, 99);
            peer = (p < 85) ? 8'($urandom_range(1, 12)) :
                   (p < 95) ? 8'($urandom_range(0, 255)) : 8'd0;
            send_request(req, v6, hi, lo, len, peer);
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int stall;
            stall = burst_mode ? 0 : $urandom_range(0, 10);
            @(negedge i_clk);
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result word arrived with no request outstanding");
            end else begin
                want = answers_due.pop_front();
                if (m_axis_tuser[1:0] !== want.status)
                    report_mismatch($sformatf("status expected %0d, got %0d",
                                              want.status, m_axis_tuser[1:0]));
                if (m_axis_tuser[2] !== want.hit)
                    report_mismatch($sformatf("hit expected %0d, got %0d",
                                              want.hit, m_axis_tuser[2]));
                if (m_axis_tdata[7:0] !== want.peer_out)
                    report_mismatch($sformatf("peer_out expected %0d, got %0d",
                                              want.peer_out, m_axis_tdata[7:0]));
                if (m_axis_tdata[14:8] !== want.count)
                    report_mismatch($sformatf("entry_count expected %0d, got %0d",
                                              want.count, m_axis_tdata[14:8]));
                if (m_axis_tdata[15] !== 1'b0)
                    report_mismatch("pad bit of the result word is not zero");
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        burst_mode    = 1'b0;
        for (int i = 0; i < ENTRIES; i++) routes[i].valid = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_edges();
        check_table_full();
        check_random_traffic();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/lpmt_pkg.sv
hdl/lpmt_ram.sv
hdl/lpmt_cmp.sv
hdl/longest_prefix_match_table_unit.sv
verif/testbench.sv
